// ===== design/binary_delta_patch_applier_defines.svh =====
// Assertion macros for the patch applier design files; only bdpa_engine includes them.
`ifndef BINARY_DELTA_PATCH_APPLIER_DEFINES_SVH
`define BINARY_DELTA_PATCH_APPLIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BDPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdpa assertion failed");

// Next-cycle implication, disabled during reset.
`define BDPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdpa assertion failed");

`endif

// ===== design/bdpa_pkg.sv =====
// Shared types and constants for the binary delta patch applier.
package bdpa_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int HEADER_BYTES       = 24;
   localparam int CSR_ADDR_WIDTH     = 3;

   localparam logic CSR_IDX_NEW_SIZE = 1'b0;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_DIFF   = 4'b0010,
      PH_EXTRA  = 4'b0100,
      PH_HALT   = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_DONE     = 3'd1,
      ST_BAD_CTRL = 3'd2,
      ST_OVERRUN  = 3'd3,
      ST_HALTED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FLD_DIFF  = 2'd0,
      FLD_EXTRA = 2'd1,
      FLD_SEEK  = 2'd2
   } field_idx_type;

   typedef struct packed {
      logic        len_bad;
      logic [30:0] len;
      logic [31:0] seek;
   } field_dec_type;

   typedef struct packed {
      logic [7:0]  new_byte;
      logic        byte_valid;
      status_type  status;
      logic        last;
      logic [31:0] old_pos;
   } result_type;

endpackage

// ===== design/bdpa_decode.sv =====
// Decodes one 8-byte sign-magnitude control field into a length and a seek.
module bdpa_decode (
   input  logic [63:0]            field,
   output bdpa_pkg::field_dec_type dec
);

   logic [62:0] mag;
   logic        neg;

   assign mag = field[62:0];
   assign neg = field[63] && (mag != '0);

   always_comb begin
      dec.len_bad = neg || (mag[62:31] != '0);
      dec.len     = dec.len_bad ? '0 : mag[30:0];
      dec.seek    = neg ? (32'd0 - mag[31:0]) : mag[31:0];
   end

endmodule

// ===== design/bdpa_engine.sv =====
// Patch state machine: header parsing, diff add, extra copy and checks.
`include "binary_delta_patch_applier_defines.svh"

module bdpa_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             patch_byte,
   input  logic [7:0]             old_byte,
   input  logic [31:0]            new_size,
   output bdpa_pkg::result_type   result
);

   bdpa_pkg::phase_type     phase_ff, phase_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [55:0]             field_ff, field_in;
   logic [30:0]             diff_ff, diff_in;
   logic [30:0]             extra_ff, extra_in;
   logic [31:0]             seek_ff, seek_in;
   logic [30:0]             rem_ff, rem_in;
   logic [31:0]             npos_ff, npos_in;
   logic [31:0]             opos_ff, opos_in;
   logic                    bad_ff, bad_in;

   bdpa_pkg::field_dec_type dec;
   bdpa_pkg::status_type    st;

   logic        is_hdr, is_diff, is_extra, step;
   logic [31:0] npos_n, opos_n, seek_sel, opos_end;
   logic [30:0] rem_n;
   logic        diff_over, extra_over, done_now;
   logic        hdr_last, field_end;
   logic [1:0]  field_idx;
   logic        do_end_diff, do_end_triple;

   bdpa_decode u_decode (
      .field ({patch_byte, field_ff}),
      .dec   (dec)
   );

   assign is_hdr   = (phase_ff == bdpa_pkg::PH_HEADER);
   assign is_diff  = (phase_ff == bdpa_pkg::PH_DIFF);
   assign is_extra = (phase_ff == bdpa_pkg::PH_EXTRA);
   assign step     = is_diff || is_extra;

   assign npos_n   = npos_ff + {31'd0, step};
   assign opos_n   = opos_ff + {31'd0, is_diff};
   assign rem_n    = rem_ff - {30'd0, (rem_ff != '0)};
   assign seek_sel = is_hdr ? dec.seek : seek_ff;
   assign opos_end = opos_n + seek_sel;

   assign diff_over  = ({1'b0, npos_ff} + {2'b0, diff_ff}) > {1'b0, new_size};
   assign extra_over = ({1'b0, npos_n} + {2'b0, extra_ff}) > {1'b0, new_size};
   assign done_now   = (npos_n >= new_size);

   assign hdr_last  = (cnt_ff == 5'(bdpa_pkg::HEADER_BYTES - 1));
   assign field_end = (cnt_ff[2:0] == 3'b111);
   assign field_idx = cnt_ff[4:3];

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      field_in      = field_ff;
      diff_in       = diff_ff;
      extra_in      = extra_ff;
      seek_in       = seek_ff;
      rem_in        = rem_ff;
      npos_in       = npos_n;
      opos_in       = opos_n;
      bad_in        = bad_ff;
      st            = bdpa_pkg::ST_RUN;
      do_end_diff   = 1'b0;
      do_end_triple = 1'b0;
      result.new_byte   = '0;
      result.byte_valid = 1'b0;

      case (phase_ff)
         bdpa_pkg::PH_HEADER: begin
            if ((cnt_ff == '0) && done_now) begin
               phase_in = bdpa_pkg::PH_HALT;
               st       = bdpa_pkg::ST_DONE;
            end else begin
               field_in = {patch_byte, field_ff[55:8]};
               if (cnt_ff == '0) begin
                  bad_in = 1'b0;
               end
               if (field_end) begin
                  case (field_idx)
                     bdpa_pkg::FLD_DIFF: begin
                        diff_in = dec.len;
                        bad_in  = bad_in || dec.len_bad;
                     end
                     bdpa_pkg::FLD_EXTRA: begin
                        extra_in = dec.len;
                        bad_in   = bad_in || dec.len_bad;
                     end
                     bdpa_pkg::FLD_SEEK: begin
                        seek_in = dec.seek;
                     end
                     default: begin
                     end
                  endcase
               end
               cnt_in = cnt_ff + 5'd1;
               if (hdr_last) begin
                  cnt_in = '0;
                  if (bad_ff || diff_over) begin
                     phase_in = bdpa_pkg::PH_HALT;
                     st       = bdpa_pkg::ST_BAD_CTRL;
                  end else if (diff_ff != '0) begin
                     phase_in = bdpa_pkg::PH_DIFF;
                     rem_in   = diff_ff;
                  end else begin
                     do_end_diff = 1'b1;
                  end
               end
            end
         end
         bdpa_pkg::PH_DIFF: begin
            result.new_byte   = patch_byte + old_byte;
            result.byte_valid = 1'b1;
            rem_in            = rem_n;
            do_end_diff       = (rem_n == '0);
         end
         bdpa_pkg::PH_EXTRA: begin
            result.new_byte   = patch_byte;
            result.byte_valid = 1'b1;
            rem_in            = rem_n;
            do_end_triple     = (rem_n == '0);
         end
         default: begin
            st = bdpa_pkg::ST_HALTED;
         end
      endcase

      if (do_end_diff) begin
         if (extra_over) begin
            phase_in = bdpa_pkg::PH_HALT;
            st       = bdpa_pkg::ST_OVERRUN;
         end else if (extra_ff != '0) begin
            phase_in = bdpa_pkg::PH_EXTRA;
            rem_in   = extra_ff;
         end else begin
            do_end_triple = 1'b1;
         end
      end

      if (do_end_triple) begin
         opos_in = opos_end;
         cnt_in  = '0;
         if (done_now) begin
            phase_in = bdpa_pkg::PH_HALT;
            st       = bdpa_pkg::ST_DONE;
         end else begin
            phase_in = bdpa_pkg::PH_HEADER;
         end
      end

      result.status  = st;
      result.last    = result.byte_valid && (st == bdpa_pkg::ST_DONE);
      result.old_pos = opos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bdpa_pkg::PH_HEADER;
         cnt_ff   <= '0;
         npos_ff  <= '0;
         opos_ff  <= '0;
         bad_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         npos_ff  <= npos_in;
         opos_ff  <= opos_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         field_ff <= field_in;
         diff_ff  <= diff_in;
         extra_ff <= extra_in;
         seek_ff  <= seek_in;
         rem_ff   <= rem_in;
      end
   end

   `BDPA_ASSERT_NEXT(a_halt_sticky, clock, reset, phase_ff == bdpa_pkg::PH_HALT, phase_ff == bdpa_pkg::PH_HALT)
   `BDPA_ASSERT_NOW(a_hdr_count, clock, reset, 1'b1, cnt_ff < 5'(bdpa_pkg::HEADER_BYTES))
   `BDPA_ASSERT_NOW(a_rem_live, clock, reset, is_diff || is_extra, rem_ff != '0)

endmodule

// ===== design/binary_delta_patch_applier.sv =====
// Top level of the binary delta patch applier: handshakes, CSR and result register.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    patch_byte, old_byte
//   rsp       out        rsp_valid/stall    new_byte, byte_valid, status, last, old_address
//   csr       in/out     APB write/read     new_size at byte address 0
//
// One request per cycle unless rsp stalls; each yields one registered response.
// The state update for a request happens in the single step stage of bdpa_engine.
// Reset is synchronous and returns the parser to the first control header byte.
// A stalled response holds the step stage; the input register then stalls req.
// A halted applier answers every request with status ST_HALTED until reset.
module binary_delta_patch_applier #(
   parameter int ADDR_WIDTH = bdpa_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_patch_byte,
   input  logic [7:0]                          req_old_byte,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_new_byte,
   output logic                                rsp_byte_valid,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last,
   output logic [ADDR_WIDTH-1:0]               rsp_old_address,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdpa_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            patch_ff, old_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            new_byte_ff;
   logic                  byte_valid_ff;
   logic [2:0]            status_ff;
   logic                  last_ff;
   logic [ADDR_WIDTH-1:0] old_addr_ff;
   logic [31:0]           new_size_ff;

   logic                  out_free, fire, req_take, csr_wr;
   logic [ADDR_WIDTH+31:0] addr_ext;
   bdpa_pkg::result_type  result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bdpa_pkg::CSR_IDX_NEW_SIZE) ? new_size_ff : '0;

   assign addr_ext = {{ADDR_WIDTH{1'b0}}, result.old_pos};

   bdpa_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .patch_byte (patch_ff),
      .old_byte   (old_ff),
      .new_size   (new_size_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         new_size_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr && (csr_paddr[2] == bdpa_pkg::CSR_IDX_NEW_SIZE)) begin
            new_size_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         patch_ff <= req_patch_byte;
         old_ff   <= req_old_byte;
      end
      if (fire) begin
         new_byte_ff   <= result.new_byte;
         byte_valid_ff <= result.byte_valid;
         status_ff     <= result.status;
         last_ff       <= result.last;
         old_addr_ff   <= addr_ext[ADDR_WIDTH-1:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_new_byte    = new_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;
   assign rsp_old_address = old_addr_ff;

endmodule
